[src/t0ts_pkg.sv]
// Package for the T=0 transport status sequencer.
// Holds the beat structs, the session state struct, action codes and status constants.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package t0ts_pkg;

   // Action codes returned with each result beat.
   localparam logic [3:0] ACT_FINISHED      = 4'd0;
   localparam logic [3:0] ACT_GET_RESPONSE  = 4'd1;
   localparam logic [3:0] ACT_RESEND        = 4'd2;
   localparam logic [3:0] ACT_BAD_INS       = 4'd3;
   localparam logic [3:0] ACT_NO_CARD       = 4'd4;
   localparam logic [3:0] ACT_NOT_CONNECTED = 4'd5;
   localparam logic [3:0] ACT_IN_USE        = 4'd6;
   localparam logic [3:0] ACT_BAD_CASE      = 4'd7;
   localparam logic [3:0] ACT_LINK_ERROR    = 4'd8;
   localparam logic [3:0] ACT_UNEXPECTED    = 4'd9;

   // Command codes on the request channel.
   localparam logic CMD_START    = 1'b0;
   localparam logic CMD_RESPONSE = 1'b1;

   // APDU case as held in the session state (case number minus one).
   localparam logic [1:0] CASE_ONE   = 2'd0;
   localparam logic [1:0] CASE_TWO   = 2'd1;
   localparam logic [1:0] CASE_THREE = 2'd2;
   localparam logic [1:0] CASE_FOUR  = 2'd3;

   // Status word constants.
   localparam logic [3:0] NIB_SW_6X      = 4'h6;
   localparam logic [3:0] NIB_SW_9X      = 4'h9;
   localparam logic [7:0] SW1_NORMAL     = 8'h90;
   localparam logic [7:0] SW2_NORMAL     = 8'h00;
   localparam logic [7:0] SW1_MORE_DATA  = 8'h61;
   localparam logic [7:0] SW1_WRONG_LE   = 8'h6C;
   localparam logic [7:0] SW1_WARN_NVM_SAME    = 8'h62;
   localparam logic [7:0] SW1_WARN_NVM_CHANGED = 8'h63;

   typedef struct packed {
      logic       command;
      logic [2:0] apdu_case;
      logic [7:0] instruction_byte;
      logic       card_present;
      logic       card_connected;
      logic       token_matches;
      logic       link_error;
      logic [7:0] status_one;
      logic [7:0] status_two;
   } req_type;

   typedef struct packed {
      logic [3:0] action;
      logic [7:0] length_expected;
      logic [7:0] final_status_one;
      logic [7:0] final_status_two;
   } rsp_type;

   typedef struct packed {
      logic       exchange_active;
      logic [1:0] active_case;
      logic       first_exchange;
      logic [7:0] saved_status_one;
      logic [7:0] saved_status_two;
   } session_type;

endpackage

`default_nettype wire

[src/t0_transport_status_sequencer.sv]
// Top level of the T=0 transport status sequencer.
// Request register, decision logic, session state and result register; uses t0ts_pkg
// and t0ts_decide.
`timescale 1ns / 1ps
`default_nettype none

// Terminal-side T=0 transport sequencer. Each request beat is either a start of a new
// command or a card status word pair, and yields exactly one result beat carrying the
// action to take (finish, GET RESPONSE, resend, or an error code), the Le to use and the
// final status words. A beat is registered on entry, decided combinationally against the
// session state and registered on exit once the result register is empty or taken; one
// beat is taken every cycle while the result side is not stalled. The session state is
// updated in the same cycle a beat is decided, so a following beat always sees the
// outcome of the previous one.
module t0_transport_status_sequencer
   import t0ts_pkg::*;
(
   input  var logic    clock,
   input  var logic    reset,
   input  var logic    req_valid,
   output logic        req_stall,
   input  var req_type req_data,
   output logic        rsp_valid,
   input  var logic    rsp_stall,
   output rsp_type     rsp_data
);

   logic        req_hold_valid_ff;
   logic        req_hold_valid_in;
   req_type     req_hold_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   rsp_type     rsp_ff;
   session_type state_ff;
   session_type state_next;
   rsp_type     rsp_next;
   logic        out_advance;
   logic        decide_fire;
   logic        req_take;

   // Handshake: the result register moves when empty or taken.
   assign out_advance  = !rsp_valid_ff || !rsp_stall;
   assign decide_fire  = req_hold_valid_ff && out_advance;
   assign req_stall    = req_hold_valid_ff && !out_advance;
   assign req_take     = req_valid && !req_stall;
   assign req_hold_valid_in = req_take || (req_hold_valid_ff && !out_advance);
   assign rsp_valid_in = decide_fire || (rsp_valid_ff && rsp_stall);

   t0ts_decide u_decide (
      .req        (req_hold_ff),
      .state      (state_ff),
      .rsp        (rsp_next),
      .state_next (state_next)
   );

   // Control and session state.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_hold_valid_ff <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         state_ff          <= '0;
      end else begin
         req_hold_valid_ff <= req_hold_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         if (decide_fire) begin
            state_ff <= state_next;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_hold_ff <= req_data;
      end
      if (decide_fire) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_stall_needs_item : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> req_hold_valid_ff)
      else $error("request stalled with an empty input register");

   a_decide_gives_result : assert property (@(posedge clock) disable iff (reset)
      decide_fire |=> rsp_valid)
      else $error("decided beat did not reach the result register");

   a_status_only_on_finish : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.action != ACT_FINISHED) |->
      (rsp_data.final_status_one == 8'h00 && rsp_data.final_status_two == 8'h00))
      else $error("final status reported on a non-finishing action");

   a_le_only_on_request : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.length_expected != 8'h00) |->
      (rsp_data.action == ACT_GET_RESPONSE || rsp_data.action == ACT_RESEND))
      else $error("length expected given with an action that sends nothing");
`endif

endmodule

`default_nettype wire

[src/t0ts_decide.sv]
// Decision logic of the T=0 transport status sequencer.
// Maps one request beat and the current session state to a result and the next state.
// Depends on t0ts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module t0ts_decide
   import t0ts_pkg::*;
(
   input  var req_type     req,
   input  var session_type state,
   output rsp_type         rsp,
   output session_type     state_next
);

   logic bad_ins;
   logic is_normal;
   logic warning;

   // Status classification.
   always_comb begin
      bad_ins   = (req.instruction_byte[7:4] == NIB_SW_6X) ||
                  (req.instruction_byte[7:4] == NIB_SW_9X);
      is_normal = (req.status_one == SW1_NORMAL) && (req.status_two == SW2_NORMAL);
      warning   = (req.status_one == SW1_WARN_NVM_SAME) ||
                  (req.status_one == SW1_WARN_NVM_CHANGED) ||
                  ((req.status_one[7:4] == NIB_SW_9X) &&
                   ((req.status_one[3:0] != 4'h0) || (req.status_two != SW2_NORMAL)));
   end

   // Main decision: start checks, then response handling by case.
   always_comb begin
      rsp        = '0;
      state_next = state;
      if (req.command == CMD_START) begin
         state_next.exchange_active = 1'b0;
         if (bad_ins) begin
            rsp.action = ACT_BAD_INS;
         end else if (!req.card_present) begin
            rsp.action = ACT_NO_CARD;
         end else if (!req.card_connected) begin
            rsp.action = ACT_NOT_CONNECTED;
         end else if (!req.token_matches) begin
            rsp.action = ACT_IN_USE;
         end else if ((req.apdu_case < 3'd1) || (req.apdu_case > 3'd4)) begin
            rsp.action = ACT_BAD_CASE;
         end else begin
            state_next.exchange_active  = 1'b1;
            state_next.active_case      = 2'(req.apdu_case - 3'd1);
            state_next.first_exchange   = 1'b1;
            state_next.saved_status_one = '0;
            state_next.saved_status_two = '0;
            rsp.action                  = ACT_RESEND;
         end
      end else if (!state.exchange_active) begin
         rsp.action = ACT_UNEXPECTED;
      end else begin
         state_next.first_exchange = 1'b0;
         if (req.link_error) begin
            state_next.exchange_active = 1'b0;
            rsp.action                 = ACT_LINK_ERROR;
         end else begin
            case (state.active_case)
               CASE_TWO: begin
                  if (!is_normal && req.status_one == SW1_MORE_DATA) begin
                     rsp.action          = ACT_GET_RESPONSE;
                     rsp.length_expected = req.status_two;
                  end else if (!is_normal && req.status_one == SW1_WRONG_LE) begin
                     rsp.action          = ACT_RESEND;
                     rsp.length_expected = req.status_two;
                  end else begin
                     state_next.exchange_active = 1'b0;
                     rsp.action                 = ACT_FINISHED;
                     rsp.final_status_one       = req.status_one;
                     rsp.final_status_two       = req.status_two;
                  end
               end
               CASE_FOUR: begin
                  if (is_normal) begin
                     state_next.exchange_active = 1'b0;
                     rsp.action                 = ACT_FINISHED;
                     // A latched warning replaces the normal ending.
                     if ((state.saved_status_one != '0) || (state.saved_status_two != '0)) begin
                        rsp.final_status_one = state.saved_status_one;
                        rsp.final_status_two = state.saved_status_two;
                     end else begin
                        rsp.final_status_one = req.status_one;
                        rsp.final_status_two = req.status_two;
                     end
                  end else if (req.status_one == SW1_MORE_DATA) begin
                     rsp.action          = ACT_GET_RESPONSE;
                     rsp.length_expected = req.status_two;
                  end else if (state.first_exchange && warning) begin
                     state_next.saved_status_one = req.status_one;
                     state_next.saved_status_two = req.status_two;
                     rsp.action                  = ACT_GET_RESPONSE;
                  end else if (req.status_one == SW1_WRONG_LE) begin
                     rsp.action          = ACT_RESEND;
                     rsp.length_expected = req.status_two;
                  end else begin
                     state_next.exchange_active = 1'b0;
                     rsp.action                 = ACT_FINISHED;
                     rsp.final_status_one       = req.status_one;
                     rsp.final_status_two       = req.status_two;
                  end
               end
               default: begin
                  // Cases one and three finish on any status word.
                  state_next.exchange_active = 1'b0;
                  rsp.action                 = ACT_FINISHED;
                  rsp.final_status_one       = req.status_one;
                  rsp.final_status_two       = req.status_two;
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire

[sim/t0ts_result_checker.sv]
// Result checker for the T=0 transport status sequencer testbench.
// Watches both channels, predicts each result beat and compares it; uses t0ts_pkg.
`timescale 1ns / 1ps

module t0ts_result_checker
   import t0ts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  rsp_type    rsp_data,
   output int         fail_count,
   output int         outstanding,
   output int         checked_beats,
   output logic [9:0] actions_seen
);

   // Private copy of the session state, advanced once per accepted request beat.
   session_type sess;

   // Expected result beats, oldest first.
   rsp_type pending_actions[$];

   // Works out the action for one request beat and moves the session state on.
   function automatic rsp_type decide_next_action(input req_type b);
      rsp_type r;
      logic    was_first;
      logic    normal_end;
      logic    warning;
      logic    close_now;
      logic [7:0] fin_one;
      logic [7:0] fin_two;
      r = '0;
      close_now = 1'b0;
      fin_one = b.status_one;
      fin_two = b.status_two;
      if (b.command == CMD_START) begin
         // A start always drops any open exchange before its checks.
         sess.exchange_active = 1'b0;
         if (b.instruction_byte[7:4] == NIB_SW_6X || b.instruction_byte[7:4] == NIB_SW_9X) begin
            r.action = ACT_BAD_INS;
         end else if (!b.card_present) begin
            r.action = ACT_NO_CARD;
         end else if (!b.card_connected) begin
            r.action = ACT_NOT_CONNECTED;
         end else if (!b.token_matches) begin
            r.action = ACT_IN_USE;
         end else if (b.apdu_case < 3'd1 || b.apdu_case > 3'd4) begin
            r.action = ACT_BAD_CASE;
         end else begin
            sess.exchange_active  = 1'b1;
            sess.active_case      = b.apdu_case[1:0] - 2'd1;
            sess.first_exchange   = 1'b1;
            sess.saved_status_one = '0;
            sess.saved_status_two = '0;
            r.action = ACT_RESEND;
         end
      end else if (!sess.exchange_active) begin
         r.action = ACT_UNEXPECTED;
      end else begin
         was_first = sess.first_exchange;
         sess.first_exchange = 1'b0;
         normal_end = (b.status_one == SW1_NORMAL) && (b.status_two == SW2_NORMAL);
         warning = (b.status_one == SW1_WARN_NVM_SAME) || (b.status_one == SW1_WARN_NVM_CHANGED)
                   || (b.status_one[7:4] == NIB_SW_9X && !normal_end);
         if (b.link_error) begin
            sess.exchange_active = 1'b0;
            r.action = ACT_LINK_ERROR;
         end else if (sess.active_case == CASE_TWO) begin
            if (normal_end) begin
               close_now = 1'b1;
            end else if (b.status_one == SW1_MORE_DATA) begin
               r.action = ACT_GET_RESPONSE;
               r.length_expected = b.status_two;
            end else if (b.status_one == SW1_WRONG_LE) begin
               r.action = ACT_RESEND;
               r.length_expected = b.status_two;
            end else begin
               close_now = 1'b1;
            end
         end else if (sess.active_case == CASE_FOUR) begin
            if (normal_end) begin
               // A warning latched on the first response replaces the normal end.
               close_now = 1'b1;
               if (sess.saved_status_one != '0 || sess.saved_status_two != '0) begin
                  fin_one = sess.saved_status_one;
                  fin_two = sess.saved_status_two;
               end
            end else if (b.status_one == SW1_MORE_DATA) begin
               r.action = ACT_GET_RESPONSE;
               r.length_expected = b.status_two;
            end else if (was_first && warning) begin
               sess.saved_status_one = b.status_one;
               sess.saved_status_two = b.status_two;
               r.action = ACT_GET_RESPONSE;
            end else if (b.status_one == SW1_WRONG_LE) begin
               r.action = ACT_RESEND;
               r.length_expected = b.status_two;
            end else begin
               close_now = 1'b1;
            end
         end else begin
            close_now = 1'b1;
         end
         if (close_now) begin
            sess.exchange_active = 1'b0;
            r.action = ACT_FINISHED;
            r.final_status_one = fin_one;
            r.final_status_two = fin_two;
         end
      end
      return r;
   endfunction

   task automatic check_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
         fail_count++;
      end
   endtask

   // Results are checked before the request of the same edge is predicted; since the
   // block registers each beat on entry and on exit, the two can never belong to each other.
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         sess = '0;
         pending_actions.delete();
         fail_count = 0;
         checked_beats = 0;
         actions_seen = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_actions.size() == 0) begin
               $error("result beat with no request outstanding: action %0d", rsp_data.action);
               fail_count++;
            end else begin
               want = pending_actions.pop_front();
               check_field("action", 8'(want.action), 8'(rsp_data.action));
               check_field("length_expected", want.length_expected, rsp_data.length_expected);
               check_field("final_status_one", want.final_status_one,
                           rsp_data.final_status_one);
               check_field("final_status_two", want.final_status_two,
                           rsp_data.final_status_two);
               if (want.action <= ACT_UNEXPECTED)
                  actions_seen[want.action] = 1'b1;
               checked_beats++;
            end
         end
         if (req_valid && !req_stall)
            pending_actions.push_back(decide_next_action(req_data));
      end
      outstanding <= pending_actions.size();
   end

endmodule

[sim/tb_t0_transport_status_sequencer.sv]
// Testbench top for the T=0 transport status sequencer.
// Drives request beats and result stalls, and gives the verdict; uses t0ts_pkg,
// t0ts_result_checker and the block itself.
`timescale 1ns / 1ps

module tb_t0_transport_status_sequencer
   import t0ts_pkg::*;
();

   localparam int LONG_HOLD = 120;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_data;

   int         fail_count;
   int         outstanding;
   int         checked_beats;
   logic [9:0] actions_seen;

   int         beats_sent;
   int         tx_idle_pct;
   int         rx_stall_pct;
   int         hold_seq;

   t0_transport_status_sequencer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   t0ts_result_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .checked_beats (checked_beats),
      .actions_seen  (actions_seen)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Watchdog for a hung handshake.
   initial begin
      #200_000;
      $display("TB_ERROR");
      $finish;
   end

   // Receiver: random stalls, plus a long hold-off each time hold_seq moves on.
   initial begin : receiver
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rx_stall_pct);
         end
      end
   end

   // Offers one request beat, after an occasional gap, and waits until it is taken.
   task automatic send_beat(input req_type b);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic req_type start_beat(input logic [2:0] cs, input logic [7:0] ins,
                                          input logic present, input logic connected,
                                          input logic token);
      req_type b;
      b = req_type'($urandom);
      b.command = CMD_START;
      b.apdu_case = cs;
      b.instruction_byte = ins;
      b.card_present = present;
      b.card_connected = connected;
      b.token_matches = token;
      return b;
   endfunction

   function automatic req_type reply_beat(input logic lnk, input logic [7:0] sw1,
                                          input logic [7:0] sw2);
      req_type b;
      b = req_type'($urandom);
      b.command = CMD_RESPONSE;
      b.link_error = lnk;
      b.status_one = sw1;
      b.status_two = sw2;
      return b;
   endfunction

   // A start that passes every check, or one that fails a chosen check.
   function automatic req_type random_start(input logic good);
      req_type b;
      int      pick;
      b = req_type'($urandom);
      b.command = CMD_START;
      if (good) begin
         while (b.instruction_byte[7:4] == NIB_SW_6X || b.instruction_byte[7:4] == NIB_SW_9X)
            b.instruction_byte = 8'($urandom);
         b.card_present = 1'b1;
         b.card_connected = 1'b1;
         b.token_matches = 1'b1;
         b.apdu_case = 3'($urandom_range(4, 1));
      end else begin
         case ($urandom_range(4))
            0: b.instruction_byte[7:4] = $urandom_range(1) ? NIB_SW_6X : NIB_SW_9X;
            1: b.card_present = 1'b0;
            2: b.card_connected = 1'b0;
            3: b.token_matches = 1'b0;
            default: begin
               pick = $urandom_range(3);
               b.apdu_case = (pick == 0) ? 3'd0 : 3'(pick + 4);
            end
         endcase
      end
      return b;
   endfunction

   // Card status words biased towards the ones that steer the exchange.
   function automatic req_type random_reply();
      req_type b;
      b = req_type'($urandom);
      b.command = CMD_RESPONSE;
      b.link_error = ($urandom_range(99) < 4);
      case ($urandom_range(6))
         0: begin
            b.status_one = SW1_NORMAL;
            b.status_two = SW2_NORMAL;
         end
         1: b.status_one = SW1_MORE_DATA;
         2: b.status_one = SW1_WRONG_LE;
         3: b.status_one = SW1_WARN_NVM_SAME;
         4: b.status_one = SW1_WARN_NVM_CHANGED;
         5: b.status_one[7:4] = NIB_SW_9X;
         default: ;
      endcase
      return b;
   endfunction

   // Mostly a start followed by a few card replies; now and then a fully random beat.
   task automatic random_exchange();
      int kind;
      kind = $urandom_range(99);
      if (kind < 8) begin
         send_beat(req_type'($urandom));
      end else begin
         send_beat(random_start(kind >= 22));
         repeat ($urandom_range(6, 1)) send_beat(random_reply());
      end
   endtask

   task automatic random_until(input int target);
      while (beats_sent < target) random_exchange();
   endtask

   // Directed beats: every action code, start check priority and the case 4 warning.
   task automatic directed_beats();
      send_beat(reply_beat(1'b0, 8'h90, 8'h00));
      send_beat(start_beat(3'd1, 8'h60, 1'b0, 1'b1, 1'b1));
      send_beat(start_beat(3'd2, 8'h00, 1'b0, 1'b1, 1'b1));
      send_beat(start_beat(3'd2, 8'h00, 1'b1, 1'b0, 1'b1));
      send_beat(start_beat(3'd2, 8'h00, 1'b1, 1'b1, 1'b0));
      send_beat(start_beat(3'd0, 8'h00, 1'b1, 1'b1, 1'b1));
      send_beat(start_beat(3'd7, 8'hFF, 1'b1, 1'b1, 1'b1));
      // Case 1 ends on any status word.
      send_beat(start_beat(3'd1, 8'h00, 1'b1, 1'b1, 1'b1));
      send_beat(reply_beat(1'b0, 8'h6A, 8'h82));
      // Case 2: more data, wrong length, then normal end.
      send_beat(start_beat(3'd2, 8'hFF, 1'b1, 1'b1, 1'b1));
      send_beat(reply_beat(1'b0, SW1_MORE_DATA, 8'h10));
      send_beat(reply_beat(1'b0, SW1_WRONG_LE, 8'hFF));
      send_beat(reply_beat(1'b0, SW1_NORMAL, SW2_NORMAL));
      // Case 4: a first-response warning is reported in place of the normal end.
      send_beat(start_beat(3'd4, 8'h5F, 1'b1, 1'b1, 1'b1));
      send_beat(reply_beat(1'b0, SW1_WARN_NVM_SAME, 8'h83));
      send_beat(reply_beat(1'b0, SW1_MORE_DATA, 8'h00));
      send_beat(reply_beat(1'b0, SW1_NORMAL, SW2_NORMAL));
      // Case 4: a warning after the first response simply ends the exchange.
      send_beat(start_beat(3'd4, 8'hA4, 1'b1, 1'b1, 1'b1));
      send_beat(reply_beat(1'b0, 8'h90, 8'h01));
      send_beat(reply_beat(1'b0, SW1_WARN_NVM_CHANGED, 8'h00));
      // A link error closes the exchange, so the next reply is unexpected.
      send_beat(start_beat(3'd4, 8'hB2, 1'b1, 1'b1, 1'b1));
      send_beat(reply_beat(1'b1, SW1_NORMAL, SW2_NORMAL));
      send_beat(reply_beat(1'b0, SW1_NORMAL, SW2_NORMAL));
      // A rejected start aborts an open exchange.
      send_beat(start_beat(3'd2, 8'h88, 1'b1, 1'b1, 1'b1));
      send_beat(start_beat(3'd2, 8'h9C, 1'b1, 1'b1, 1'b1));
      send_beat(reply_beat(1'b0, SW1_MORE_DATA, 8'h05));
   endtask

   initial begin : stimulus
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      beats_sent = 0;
      tx_idle_pct = 0;
      rx_stall_pct = 0;
      hold_seq = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Sender rarely idle, receiver often stalled.
      tx_idle_pct = 12;
      rx_stall_pct <= 47;
      directed_beats();
      random_until(200);
      wait_until_drained();

      // The other way round.
      tx_idle_pct = 47;
      rx_stall_pct <= 12;
      random_until(370);
      wait_until_drained();

      // No idling; a long receiver hold-off fills the block while beats keep coming.
      tx_idle_pct = 0;
      rx_stall_pct <= 0;
      hold_seq <= hold_seq + 1;
      random_until(550);

      wait_until_drained();
      repeat (8) @(posedge clock);

      $display("Run covered %0d request beats and %0d checked result beats,",
               beats_sent, checked_beats);
      $display("in three idling phases with %0d of 10 action codes and a long hold-off.",
               $countones(actions_seen));
      if (fail_count == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
